@@ design/ippr_pkg.sv @@
// ----------------------------------------------------------------------------
// ippr_pkg
// Shared types and constants of the incremental PID pressure regulator.
// ----------------------------------------------------------------------------
package ippr_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ERR_POS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ERR_NEG = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW     = 3'd7;

  localparam logic [19:0] RST_SETPOINT    = 20'd1500;
  localparam logic [9:0]  RST_GAIN_PROP   = 10'd10;
  localparam logic [9:0]  RST_GAIN_INTEG  = 10'd15;
  localparam logic [9:0]  RST_GAIN_DERIV  = 10'd0;
  localparam logic [19:0] RST_MAX_ERR_POS = 20'd100;
  localparam logic [19:0] RST_MAX_ERR_NEG = 20'd100;
  localparam logic [23:0] RST_OUT_HIGH    = 24'd1280000;
  localparam logic [23:0] RST_OUT_LOW     = 24'd38400;

  typedef struct packed {
    logic [19:0] setpoint;
    logic [9:0]  gain_prop;
    logic [9:0]  gain_integ;
    logic [9:0]  gain_deriv;
    logic [19:0] max_err_pos;
    logic [19:0] max_err_neg;
    logic [23:0] out_high;
    logic [23:0] out_low;
  } cfg_t;

  typedef struct packed {
    logic [23:0]        acc;
    logic signed [20:0] err;
    logic               clipped;
    logic               limited;
  } law_t;

endpackage

@@ design/ippr_cfg.sv @@
// ----------------------------------------------------------------------------
// ippr_cfg
// Configuration register bank, written one word per enabled cycle.
// ----------------------------------------------------------------------------
module ippr_cfg
  import ippr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SETPOINT:    cfg_nxt.setpoint    = cfg_wdata[19:0];
        REG_GAIN_PROP:   cfg_nxt.gain_prop   = cfg_wdata[9:0];
        REG_GAIN_INTEG:  cfg_nxt.gain_integ  = cfg_wdata[9:0];
        REG_GAIN_DERIV:  cfg_nxt.gain_deriv  = cfg_wdata[9:0];
        REG_MAX_ERR_POS: cfg_nxt.max_err_pos = cfg_wdata[19:0];
        REG_MAX_ERR_NEG: cfg_nxt.max_err_neg = cfg_wdata[19:0];
        REG_OUT_HIGH:    cfg_nxt.out_high    = cfg_wdata;
        REG_OUT_LOW:     cfg_nxt.out_low     = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint    <= RST_SETPOINT;
      cfg_r.gain_prop   <= RST_GAIN_PROP;
      cfg_r.gain_integ  <= RST_GAIN_INTEG;
      cfg_r.gain_deriv  <= RST_GAIN_DERIV;
      cfg_r.max_err_pos <= RST_MAX_ERR_POS;
      cfg_r.max_err_neg <= RST_MAX_ERR_NEG;
      cfg_r.out_high    <= RST_OUT_HIGH;
      cfg_r.out_low     <= RST_OUT_LOW;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/ippr_law.sv @@
// ----------------------------------------------------------------------------
// ippr_law
// Velocity-form control law: error clip, gain terms, accumulate (bypassed when ki is zero) and clamp.
// ----------------------------------------------------------------------------
module ippr_law
  import ippr_pkg::*;
(
  input  cfg_t               cfg,
  input  logic [19:0]        measured,
  input  logic [23:0]        accum,
  input  logic signed [20:0] err_prev1,
  input  logic signed [20:0] err_prev2,
  output law_t               law
);

  logic               pd_mode;
  logic [11:0]        k1;
  logic signed [13:0] k2_num;
  logic signed [13:0] k2_adj;
  logic signed [12:0] k2;
  logic [9:0]         k3;
  logic signed [21:0] err_raw;
  logic signed [21:0] lim_pos;
  logic signed [21:0] lim_neg;
  logic signed [20:0] err;
  logic               clipped;
  logic signed [12:0] k1_s;
  logic signed [10:0] k3_s;
  logic signed [33:0] p1;
  logic signed [33:0] p2;
  logic signed [31:0] p3;
  logic signed [39:0] base;
  logic signed [39:0] sum;
  logic signed [39:0] hi;
  logic signed [39:0] lo;

  assign pd_mode = (cfg.gain_integ == 10'd0);

  // K2 numerator is 2kp + 4kd - ki, halved toward zero
  assign k2_num = signed'(14'({cfg.gain_prop, 1'b0}) + 14'({cfg.gain_deriv, 2'b00})
                          - 14'(cfg.gain_integ));
  assign k2_adj = k2_num + signed'(14'(k2_num[13] & k2_num[0]));

  always_comb begin
    if (pd_mode) begin
      k1 = 12'(cfg.gain_prop) + 12'(cfg.gain_deriv);
      k2 = signed'(13'(cfg.gain_deriv));
      k3 = 10'd0;
    end else begin
      k1 = 12'(cfg.gain_prop) + 12'(cfg.gain_deriv) + 12'(cfg.gain_integ[9:1]);
      k2 = k2_adj[13:1];
      k3 = cfg.gain_deriv;
    end
  end

  assign err_raw = signed'({2'b00, cfg.setpoint}) - signed'({2'b00, measured});
  assign lim_pos = signed'({2'b00, cfg.max_err_pos});
  assign lim_neg = -signed'({2'b00, cfg.max_err_neg});

  always_comb begin
    clipped = 1'b0;
    err     = err_raw[20:0];
    if (err_raw > lim_pos) begin
      err     = lim_pos[20:0];
      clipped = 1'b1;
    end else if (err_raw < lim_neg) begin
      err     = lim_neg[20:0];
      clipped = 1'b1;
    end
  end

  assign k1_s = signed'({1'b0, k1});
  assign k3_s = signed'({1'b0, k3});
  assign p1   = k1_s * err;
  assign p2   = k2 * err_prev1;
  assign p3   = k3_s * err_prev2;

  assign base = pd_mode ? 40'sd0 : signed'({16'd0, accum});
  assign sum  = base + 40'(p1) - 40'(p2) + 40'(p3);
  assign hi   = signed'({16'd0, cfg.out_high});
  assign lo   = signed'({16'd0, cfg.out_low});

  always_comb begin
    law.err     = err;
    law.clipped = clipped;
    law.limited = 1'b0;
    law.acc     = sum[23:0];
    if (sum > hi) begin
      law.acc     = cfg.out_high;
      law.limited = 1'b1;
    end else if (sum < lo) begin
      law.acc     = cfg.out_low;
      law.limited = 1'b1;
    end
  end

endmodule

@@ design/incremental_pid_pressure_regulator_unit.sv @@
// ----------------------------------------------------------------------------
// incremental_pid_pressure_regulator_unit
// Incremental PID pump pressure regulator with a drive accumulator.
//
//   channel | signals                                   | dir
//   in      | in_valid in_ready in_kind in_measured     | sink
//   out     | out_valid out_ready out_drive             | source
//           | out_err_clipped out_out_limited           |
//   cfg     | cfg_we cfg_index cfg_wdata                | sink
//
// One word per cycle sustained while out is not stalled; a taken word goes through
// the input register, then the law and result register in one pass, to out.
// The accumulator feedback closes within the result cycle, so words follow
// back to back.
// Reset is synchronous; state and configuration return to their defaults.
// A stalled out channel holds the result and backs up into the input register.
// ----------------------------------------------------------------------------
module incremental_pid_pressure_regulator_unit
  import ippr_pkg::*;
#(
  parameter int SHIFT    = 8,
  parameter int START_HZ = 200
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [19:0]           in_measured,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_drive,
  output logic                  out_err_clipped,
  output logic                  out_out_limited,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [47:0] START_WIDE = 48'(START_HZ) << SHIFT;
  localparam logic [23:0] START_ACC  = START_WIDE[23:0];

  cfg_t cfg;
  law_t law;

  logic               s1_valid_r;
  logic               kind_r;
  logic [19:0]        meas_r;
  logic               adv;

  logic [23:0]        accum_r;
  logic [23:0]        accum_nxt;
  logic signed [20:0] err1_r;
  logic signed [20:0] err1_nxt;
  logic signed [20:0] err2_r;
  logic signed [20:0] err2_nxt;

  logic               out_valid_r;
  logic [15:0]        drive_r;
  logic               clipped_r;
  logic               clipped_nxt;
  logic               limited_r;
  logic               limited_nxt;

  ippr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  ippr_law u_law (
    .cfg      (cfg),
    .measured (meas_r),
    .accum    (accum_r),
    .err_prev1(err1_r),
    .err_prev2(err2_r),
    .law      (law)
  );

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= in_kind;
      meas_r <= in_measured;
    end
  end

  always_comb begin
    if (kind_r) begin
      accum_nxt   = START_ACC;
      err1_nxt    = 21'sd0;
      err2_nxt    = 21'sd0;
      clipped_nxt = 1'b0;
      limited_nxt = 1'b0;
    end else begin
      accum_nxt   = law.acc;
      err1_nxt    = law.err;
      err2_nxt    = err1_r;
      clipped_nxt = law.clipped;
      limited_nxt = law.limited;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= 24'd0;
      err1_r  <= 21'sd0;
      err2_r  <= 21'sd0;
    end else if (adv) begin
      accum_r <= accum_nxt;
      err1_r  <= err1_nxt;
      err2_r  <= err2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drive_r   <= 16'(accum_nxt >> SHIFT);
      clipped_r <= clipped_nxt;
      limited_r <= limited_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive       = drive_r;
  assign out_err_clipped = clipped_r;
  assign out_out_limited = limited_r;

endmodule

@@ design/ippr_chk.sv @@
// ----------------------------------------------------------------------------
// ippr_chk
// Port-level checks of the regulator handshake and latency.
// ----------------------------------------------------------------------------
module ippr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_drive,
  input logic        out_err_clipped,
  input logic        out_out_limited
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive)
      && $stable(out_err_clipped) && $stable(out_out_limited))
    else $error("stalled result changed");

  // back-pressure only from a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // a taken word reaches the result port
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("result missing after accepted word");

endmodule

bind incremental_pid_pressure_regulator_unit ippr_chk u_ippr_chk (.*);
